FILE: hdl/rys_pkg.sv
// Shared types and constants for the RGB to Y'UV gain-scaling pixel pipeline.
`default_nettype none

package rys_pkg;

    // Pixel component and gain widths
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned GAIN_W = 8;

    // Forward matrix sums fit in 18 signed bits, inverse sums in 20
    localparam int unsigned FWD_W = 18;
    localparam int unsigned INV_W = 20;

    // Inverse matrix operands (Y - 16, U - 128, V - 128) fit in 10 signed bits
    localparam int unsigned DIFF_W = 10;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_GAIN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_CHROMA_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_CHROMA_GAIN  = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 8'd128;

    // Forward BT.601 coefficients
    localparam logic signed [FWD_W-1:0] K_YR = 18'sd66;
    localparam logic signed [FWD_W-1:0] K_YG = 18'sd129;
    localparam logic signed [FWD_W-1:0] K_YB = 18'sd25;
    localparam logic signed [FWD_W-1:0] K_UR = -18'sd38;
    localparam logic signed [FWD_W-1:0] K_UG = -18'sd74;
    localparam logic signed [FWD_W-1:0] K_UB = 18'sd112;
    localparam logic signed [FWD_W-1:0] K_VR = 18'sd112;
    localparam logic signed [FWD_W-1:0] K_VG = -18'sd94;
    localparam logic signed [FWD_W-1:0] K_VB = -18'sd18;
    localparam logic signed [FWD_W-1:0] K_FWD_RND = 18'sd128;

    localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;
    localparam logic [PIX_W-1:0] C_OFFSET = 8'd128;

    // Inverse coefficients
    localparam logic signed [INV_W-1:0] K_C  = 20'sd298;
    localparam logic signed [INV_W-1:0] K_RE = 20'sd409;
    localparam logic signed [INV_W-1:0] K_GD = -20'sd100;
    localparam logic signed [INV_W-1:0] K_GE = -20'sd208;
    localparam logic signed [INV_W-1:0] K_BD = 20'sd516;
    localparam logic signed [INV_W-1:0] K_INV_RND = 20'sd128;

    localparam logic signed [DIFF_W-1:0] Y_OFFSET_S = 10'sd16;
    localparam logic signed [DIFF_W-1:0] C_OFFSET_S = 10'sd128;

    // Control that travels with each pixel down the pipeline
    typedef struct packed {
        logic valid;
        logic frame_end;
    } stage_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/rys_fwd.sv
// Stage 1: forward BT.601 matrix products and sums.
`default_nettype none

module rys_fwd (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire rys_pkg::stage_ctl_t                    ctl_in,
    input  wire logic [rys_pkg::PIX_W-1:0]              red,
    input  wire logic [rys_pkg::PIX_W-1:0]              green,
    input  wire logic [rys_pkg::PIX_W-1:0]              blue,
    output rys_pkg::stage_ctl_t                         ctl_out,
    output logic signed [rys_pkg::FWD_W-1:0]            sum_y,
    output logic signed [rys_pkg::FWD_W-1:0]            sum_u,
    output logic signed [rys_pkg::FWD_W-1:0]            sum_v
);

    localparam int unsigned EXT_W = rys_pkg::FWD_W - rys_pkg::PIX_W;

    rys_pkg::stage_ctl_t ctl_reg;
    logic signed [rys_pkg::FWD_W-1:0] sum_y_reg, sum_u_reg, sum_v_reg;
    logic signed [rys_pkg::FWD_W-1:0] sum_y_next, sum_u_next, sum_v_next;
    logic signed [rys_pkg::FWD_W-1:0] r_s, g_s, b_s;

    always_comb begin
        r_s = signed'({{EXT_W{1'b0}}, red});
        g_s = signed'({{EXT_W{1'b0}}, green});
        b_s = signed'({{EXT_W{1'b0}}, blue});
        sum_y_next = rys_pkg::K_YR * r_s + rys_pkg::K_YG * g_s + rys_pkg::K_YB * b_s
                   + rys_pkg::K_FWD_RND;
        sum_u_next = rys_pkg::K_UR * r_s + rys_pkg::K_UG * g_s + rys_pkg::K_UB * b_s
                   + rys_pkg::K_FWD_RND;
        sum_v_next = rys_pkg::K_VR * r_s + rys_pkg::K_VG * g_s + rys_pkg::K_VB * b_s
                   + rys_pkg::K_FWD_RND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_y_reg <= sum_y_next;
            sum_u_reg <= sum_u_next;
            sum_v_reg <= sum_v_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign sum_y   = sum_y_reg;
    assign sum_u   = sum_u_reg;
    assign sum_v   = sum_v_reg;

endmodule

`default_nettype wire

FILE: hdl/rys_scale.sv
// Stage 2: floor shift and offsets to 8-bit Y'UV, then per-component gain.
`default_nettype none

module rys_scale (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire rys_pkg::stage_ctl_t                    ctl_in,
    input  wire logic signed [rys_pkg::FWD_W-1:0]       sum_y,
    input  wire logic signed [rys_pkg::FWD_W-1:0]       sum_u,
    input  wire logic signed [rys_pkg::FWD_W-1:0]       sum_v,
    input  wire logic [rys_pkg::GAIN_W-1:0]             gain_y,
    input  wire logic [rys_pkg::GAIN_W-1:0]             gain_u,
    input  wire logic [rys_pkg::GAIN_W-1:0]             gain_v,
    output rys_pkg::stage_ctl_t                         ctl_out,
    output logic [rys_pkg::PIX_W-1:0]                   y_out,
    output logic [rys_pkg::PIX_W-1:0]                   u_out,
    output logic [rys_pkg::PIX_W-1:0]                   v_out
);

    localparam int unsigned PROD_W = rys_pkg::PIX_W + rys_pkg::GAIN_W;

    rys_pkg::stage_ctl_t ctl_reg;
    logic [rys_pkg::PIX_W-1:0] y_reg, u_reg, v_reg;
    logic [rys_pkg::PIX_W-1:0] y_next, u_next, v_next;
    logic [rys_pkg::PIX_W-1:0] y8, u8, v8;
    logic [PROD_W-1:0] prod_y, prod_u, prod_v;

    always_comb begin
        // low byte of floor(sum / 256) is sum[15:8]
        y8 = sum_y[15:8] + rys_pkg::Y_OFFSET;
        u8 = sum_u[15:8] + rys_pkg::C_OFFSET;
        v8 = sum_v[15:8] + rys_pkg::C_OFFSET;
        prod_y = PROD_W'(y8) * PROD_W'(gain_y);
        prod_u = PROD_W'(u8) * PROD_W'(gain_u);
        prod_v = PROD_W'(v8) * PROD_W'(gain_v);
        // shift right by seven and keep the low byte (wraps on overflow)
        y_next = prod_y[14:7];
        u_next = prod_u[14:7];
        v_next = prod_v[14:7];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign y_out   = y_reg;
    assign u_out   = u_reg;
    assign v_out   = v_reg;

endmodule

`default_nettype wire

FILE: hdl/rys_inv.sv
// Stage 3: inverse matrix products and sums back toward RGB.
`default_nettype none

module rys_inv (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire rys_pkg::stage_ctl_t                    ctl_in,
    input  wire logic [rys_pkg::PIX_W-1:0]              y_in,
    input  wire logic [rys_pkg::PIX_W-1:0]              u_in,
    input  wire logic [rys_pkg::PIX_W-1:0]              v_in,
    output rys_pkg::stage_ctl_t                         ctl_out,
    output logic signed [rys_pkg::INV_W-1:0]            sum_r,
    output logic signed [rys_pkg::INV_W-1:0]            sum_g,
    output logic signed [rys_pkg::INV_W-1:0]            sum_b
);

    localparam int unsigned DEXT_W = rys_pkg::DIFF_W - rys_pkg::PIX_W;

    rys_pkg::stage_ctl_t ctl_reg;
    logic signed [rys_pkg::INV_W-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic signed [rys_pkg::INV_W-1:0] sum_r_next, sum_g_next, sum_b_next;
    logic signed [rys_pkg::DIFF_W-1:0] c_s, d_s, e_s;
    logic signed [rys_pkg::INV_W-1:0] c_x, d_x, e_x;

    always_comb begin
        c_s = signed'({{DEXT_W{1'b0}}, y_in}) - rys_pkg::Y_OFFSET_S;
        d_s = signed'({{DEXT_W{1'b0}}, u_in}) - rys_pkg::C_OFFSET_S;
        e_s = signed'({{DEXT_W{1'b0}}, v_in}) - rys_pkg::C_OFFSET_S;
        c_x = rys_pkg::INV_W'(c_s);
        d_x = rys_pkg::INV_W'(d_s);
        e_x = rys_pkg::INV_W'(e_s);
        sum_r_next = rys_pkg::K_C * c_x + rys_pkg::K_RE * e_x + rys_pkg::K_INV_RND;
        sum_g_next = rys_pkg::K_C * c_x + rys_pkg::K_GD * d_x + rys_pkg::K_GE * e_x
                   + rys_pkg::K_INV_RND;
        sum_b_next = rys_pkg::K_C * c_x + rys_pkg::K_BD * d_x + rys_pkg::K_INV_RND;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign sum_r   = sum_r_reg;
    assign sum_g   = sum_g_reg;
    assign sum_b   = sum_b_reg;

endmodule

`default_nettype wire

FILE: hdl/rys_clamp.sv
// Stage 4: floor shift, clamp to 0..255 and output register.
`default_nettype none

module rys_clamp (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   en,
    input  wire rys_pkg::stage_ctl_t                    ctl_in,
    input  wire logic signed [rys_pkg::INV_W-1:0]       sum_r,
    input  wire logic signed [rys_pkg::INV_W-1:0]       sum_g,
    input  wire logic signed [rys_pkg::INV_W-1:0]       sum_b,
    output rys_pkg::stage_ctl_t                         ctl_out,
    output logic [rys_pkg::PIX_W-1:0]                   red,
    output logic [rys_pkg::PIX_W-1:0]                   green,
    output logic [rys_pkg::PIX_W-1:0]                   blue
);

    rys_pkg::stage_ctl_t ctl_reg;
    logic [rys_pkg::PIX_W-1:0] red_reg, green_reg, blue_reg;
    logic [rys_pkg::PIX_W-1:0] red_next, green_next, blue_next;

    function automatic logic [rys_pkg::PIX_W-1:0] clamp_byte(
        input logic signed [rys_pkg::INV_W-1:0] s
    );
        logic [rys_pkg::PIX_W-1:0] res;
        // s[19:8] is floor(s / 256); negative drops to 0, above 255 holds 255
        if (s[rys_pkg::INV_W-1]) begin
            res = '0;
        end else if (|s[rys_pkg::INV_W-2:16]) begin
            res = '1;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    always_comb begin
        red_next   = clamp_byte(sum_r);
        green_next = clamp_byte(sum_g);
        blue_next  = clamp_byte(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign red     = red_reg;
    assign green   = green_reg;
    assign blue    = blue_reg;

endmodule

`default_nettype wire

FILE: hdl/rgb_yuv_scale_rgb_pixel_top.sv
// Top level of the RGB to Y'UV gain-scaling color balance pipeline.
`default_nettype none

// Color balance filter for an 8-bit RGB pixel stream. Each pixel is converted
// to Y'UV with the integer BT.601 matrix, Y, U and V are each multiplied by
// their own 8-bit gain (128 = unity, result shifted right by seven and wrapped
// to 8 bits), and the result is converted back to RGB and clamped to 0..255.
// The frame_end flag rides along with its pixel unchanged. The block takes one
// pixel per clock unless a stalled m_ready has backed the pipeline up into
// s_ready. The four register stages (forward matrix, gain multiply, inverse
// matrix, clamp/output) each advance independently, so bubbles collapse and a
// stalled m_ready only backs up the stages that actually hold pixels. Gains
// are written on the cfg_ port (index 0 luma, 1 blue chroma, 2 red chroma;
// index 3 is ignored), always accepted, and must only change while no pixel
// is in flight. All gains reset to 128.

module rgb_yuv_scale_rgb_pixel_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Pixel input
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rys_pkg::PIX_W-1:0]         s_red_in,
    input  wire logic [rys_pkg::PIX_W-1:0]         s_green_in,
    input  wire logic [rys_pkg::PIX_W-1:0]         s_blue_in,
    input  wire logic                              s_frame_end,

    // Pixel output
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [rys_pkg::PIX_W-1:0]              m_red_out,
    output logic [rys_pkg::PIX_W-1:0]              m_green_out,
    output logic [rys_pkg::PIX_W-1:0]              m_blue_out,
    output logic                                   m_frame_end_out,

    // Gain register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rys_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rys_pkg::GAIN_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Gain registers
    // ------------------------------------------------------------------
    logic [rys_pkg::GAIN_W-1:0] gain_y_reg, gain_u_reg, gain_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_y_reg <= rys_pkg::GAIN_UNITY;
            gain_u_reg <= rys_pkg::GAIN_UNITY;
            gain_v_reg <= rys_pkg::GAIN_UNITY;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rys_pkg::REG_LUMA_GAIN:        gain_y_reg <= cfg_data;
                rys_pkg::REG_BLUE_CHROMA_GAIN: gain_u_reg <= cfg_data;
                rys_pkg::REG_RED_CHROMA_GAIN:  gain_v_reg <= cfg_data;
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or when the
    // stage after it advances. The last stage is the output register.
    // ------------------------------------------------------------------
    rys_pkg::stage_ctl_t ctl_in, ctl1, ctl2, ctl3, ctl4;
    logic en1, en2, en3, en4;

    assign en4 = !ctl4.valid || m_ready;
    assign en3 = !ctl3.valid || en4;
    assign en2 = !ctl2.valid || en3;
    assign en1 = !ctl1.valid || en2;

    assign s_ready = en1;

    always_comb begin
        ctl_in.valid     = s_valid;
        ctl_in.frame_end = s_frame_end;
    end

    // ------------------------------------------------------------------
    // Datapath stages
    // ------------------------------------------------------------------
    logic signed [rys_pkg::FWD_W-1:0] sum_y, sum_u, sum_v;
    logic [rys_pkg::PIX_W-1:0] y_sc, u_sc, v_sc;
    logic signed [rys_pkg::INV_W-1:0] sum_r, sum_g, sum_b;

    // Forward matrix: RGB to Y'UV pre-shift sums
    rys_fwd u_fwd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en1),
        .ctl_in  (ctl_in),
        .red     (s_red_in),
        .green   (s_green_in),
        .blue    (s_blue_in),
        .ctl_out (ctl1),
        .sum_y   (sum_y),
        .sum_u   (sum_u),
        .sum_v   (sum_v)
    );

    // Shift, offset and apply gains
    rys_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en2),
        .ctl_in  (ctl1),
        .sum_y   (sum_y),
        .sum_u   (sum_u),
        .sum_v   (sum_v),
        .gain_y  (gain_y_reg),
        .gain_u  (gain_u_reg),
        .gain_v  (gain_v_reg),
        .ctl_out (ctl2),
        .y_out   (y_sc),
        .u_out   (u_sc),
        .v_out   (v_sc)
    );

    // Inverse matrix back to RGB sums
    rys_inv u_inv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en3),
        .ctl_in  (ctl2),
        .y_in    (y_sc),
        .u_in    (u_sc),
        .v_in    (v_sc),
        .ctl_out (ctl3),
        .sum_r   (sum_r),
        .sum_g   (sum_g),
        .sum_b   (sum_b)
    );

    // Clamp into the output register
    rys_clamp u_clamp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en4),
        .ctl_in  (ctl3),
        .sum_r   (sum_r),
        .sum_g   (sum_g),
        .sum_b   (sum_b),
        .ctl_out (ctl4),
        .red     (m_red_out),
        .green   (m_green_out),
        .blue    (m_blue_out)
    );

    assign m_valid         = ctl4.valid;
    assign m_frame_end_out = ctl4.frame_end;

endmodule

`default_nettype wire

FILE: hdl/rys_check.sv
// Port-level assertions for the color balance pipeline, bound to its top level.
`default_nettype none

module rys_check (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [rys_pkg::PIX_W-1:0]   m_red_out,
    input wire logic [rys_pkg::PIX_W-1:0]   m_green_out,
    input wire logic [rys_pkg::PIX_W-1:0]   m_blue_out,
    input wire logic                        m_frame_end_out
);

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_frame_end_out))
        else $error("stalled result changed");

    // An empty output register never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // A draining output never blocks the input
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

bind rgb_yuv_scale_rgb_pixel_top rys_check u_rys_check (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_red_out       (m_red_out),
    .m_green_out     (m_green_out),
    .m_blue_out      (m_blue_out),
    .m_frame_end_out (m_frame_end_out)
);

`default_nettype wire

FILE: verif/rgb_yuv_scale_rgb_pixel_top_tb.sv
// Self-checking bench for the color balance pipeline: table and random pixels vs. a local model.
`timescale 1ns / 100ps

module rgb_yuv_scale_rgb_pixel_top_tb;

    // Index 3 is not a gain register; writes to it must leave every gain alone.
    localparam logic [rys_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int N_PROBES    = 21;
    localparam int N_PHASES    = 6;
    localparam int PHASE_ITEMS = 125;
    localparam int HOLD_AT     = 120;  // results seen before the long sink hold-off
    localparam int HOLD_CYCLES = 64;
    localparam int TAIL_CYCLES = 12;   // idle watch for stray results after the four stages drain

    typedef struct packed {
        logic [rys_pkg::PIX_W-1:0] red;
        logic [rys_pkg::PIX_W-1:0] green;
        logic [rys_pkg::PIX_W-1:0] blue;
        logic                      frame_end;
    } pixel_t;

    // One row of the directed table: gains to run under, pixel to send, and an
    // optional typed-in result for the rows whose answer is obvious.
    typedef struct packed {
        logic [rys_pkg::GAIN_W-1:0] gy;
        logic [rys_pkg::GAIN_W-1:0] gu;
        logic [rys_pkg::GAIN_W-1:0] gv;
        logic                       spare;
        pixel_t                     stim;
        logic                       typed;
        pixel_t                     want;
    } probe_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    logic [rys_pkg::PIX_W-1:0] s_red_in    = '0;
    logic [rys_pkg::PIX_W-1:0] s_green_in  = '0;
    logic [rys_pkg::PIX_W-1:0] s_blue_in   = '0;
    logic                      s_frame_end = 1'b0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [rys_pkg::PIX_W-1:0] m_red_out;
    logic [rys_pkg::PIX_W-1:0] m_green_out;
    logic [rys_pkg::PIX_W-1:0] m_blue_out;
    logic                      m_frame_end_out;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [rys_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rys_pkg::GAIN_W-1:0]    cfg_data  = '0;

    // Tag carried next to the offered pixel so the scoreboard knows whether a
    // typed-in result applies to this transfer.
    logic   typed_tag = 1'b0;
    pixel_t want_tag  = '0;

    // Local copy of the gain registers, as of the last accepted write.
    logic [rys_pkg::GAIN_W-1:0] gain_luma = rys_pkg::GAIN_UNITY;
    logic [rys_pkg::GAIN_W-1:0] gain_blue = rys_pkg::GAIN_UNITY;
    logic [rys_pkg::GAIN_W-1:0] gain_red  = rys_pkg::GAIN_UNITY;

    pixel_t pending_colors[$];
    int     sent_count = 0;
    int     rcvd_count = 0;
    int     fail_count = 0;
    bit     calm       = 1'b0;  // set for the last phase: no idling on either side

    // Columns: luma, blue, red gain, poke index 3 first, pixel, typed?, result.
    probe_t probe_tbl [0:N_PROBES-1] = '{
        // unity gains: black and white come back unchanged
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'hff, 8'hff, 8'hff, 1'b1}, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b1}},
        // primaries, secondaries, grey and mixed levels: negative chroma sums, clamping on both ends
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'hff, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h00, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h00, 8'h00, 8'hff, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'hff, 8'hff, 8'h00, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h00, 8'hff, 8'hff, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'hff, 8'h00, 8'hff, 1'b1}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h80, 8'h80, 8'h80, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'haa, 8'h55, 8'haa, 1'b0}, 1'b0, '0},
        '{8'h80, 8'h80, 8'h80, 1'b0, '{8'h55, 8'haa, 8'h55, 1'b1}, 1'b0, '0},
        // write to the unused index: white must still pass at unity
        '{8'h80, 8'h80, 8'h80, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, '{8'hff, 8'hff, 8'hff, 1'b0}},
        // all gains zero: every pixel lands on the same dark green
        '{8'h00, 8'h00, 8'h00, 1'b0, '{8'hff, 8'hff, 8'hff, 1'b0}, 1'b1, '{8'h00, 8'h87, 8'h00, 1'b0}},
        '{8'h00, 8'h00, 8'h00, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b1}, 1'b1, '{8'h00, 8'h87, 8'h00, 1'b1}},
        // full gains: scaled Y'UV wraps past 8 bits
        '{8'hff, 8'hff, 8'hff, 1'b0, '{8'hff, 8'hff, 8'hff, 1'b0}, 1'b0, '0},
        '{8'hff, 8'hff, 8'hff, 1'b0, '{8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{8'hff, 8'hff, 8'hff, 1'b0, '{8'hff, 8'h00, 8'h00, 1'b0}, 1'b0, '0},
        '{8'hff, 8'hff, 8'hff, 1'b0, '{8'h00, 8'h00, 8'hff, 1'b1}, 1'b0, '0},
        // mixed gains, one channel at each extreme or just inside it
        '{8'h80, 8'h00, 8'hff, 1'b0, '{8'hc8, 8'h1e, 8'h5a, 1'b0}, 1'b0, '0},
        '{8'hff, 8'h80, 8'h00, 1'b0, '{8'h1e, 8'hc8, 8'h5a, 1'b1}, 1'b0, '0},
        '{8'h01, 8'hfe, 8'h7f, 1'b0, '{8'h7f, 8'h80, 8'hfe, 1'b0}, 1'b0, '0}
    };

    rgb_yuv_scale_rgb_pixel_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_red_in        (s_red_in),
        .s_green_in      (s_green_in),
        .s_blue_in       (s_blue_in),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end_out (m_frame_end_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Color balance model
    // ---------------------------------------------------------------------

    // Multiply by a gain (128 = unity), drop seven bits, keep the low byte.
    function automatic logic [rys_pkg::PIX_W-1:0] apply_gain(
        input logic [rys_pkg::PIX_W-1:0] level,
        input logic [rys_pkg::GAIN_W-1:0] gain
    );
        logic [rys_pkg::PIX_W+rys_pkg::GAIN_W-1:0] prod;
        prod = level * gain;
        return prod[rys_pkg::PIX_W+6:7];
    endfunction

    function automatic logic [rys_pkg::PIX_W-1:0] clamp_level(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return '1;
        return rys_pkg::PIX_W'(v);
    endfunction

    // RGB -> Y'UV, per-component gain, Y'UV -> RGB with clamping. The >>> on
    // a signed int floors, which is what the hardware shift does too.
    function automatic pixel_t balance_pixel(input pixel_t px);
        int                        r, g, b, c, d, e;
        logic [rys_pkg::PIX_W-1:0] ys, us, vs;
        pixel_t                    res;
        r  = int'(px.red);
        g  = int'(px.green);
        b  = int'(px.blue);
        ys = rys_pkg::PIX_W'(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
        us = rys_pkg::PIX_W'(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
        vs = rys_pkg::PIX_W'(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
        ys = apply_gain(ys, gain_luma);
        us = apply_gain(us, gain_blue);
        vs = apply_gain(vs, gain_red);
        c  = int'(ys) - 16;
        d  = int'(us) - 128;
        e  = int'(vs) - 128;
        res.red       = clamp_level((298 * c + 409 * e + 128) >>> 8);
        res.green     = clamp_level((298 * c - 100 * d - 208 * e + 128) >>> 8);
        res.blue      = clamp_level((298 * c + 516 * d + 128) >>> 8);
        res.frame_end = px.frame_end;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: everything is sampled at the rising edge, so inputs and
    // outputs show their pre-edge values and no ordering race can arise.
    // ---------------------------------------------------------------------

    function automatic void check_field(input string name,
                                        input logic [rys_pkg::PIX_W-1:0] want_v,
                                        input logic [rys_pkg::PIX_W-1:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        pixel_t want;
        if (aresetn) begin
            // Retire the oldest expectation on each output transfer.
            if (m_valid && m_ready) begin
                if (pending_colors.size() == 0) begin
                    $error("unexpected pixel transfer: red %0d green %0d blue %0d",
                           m_red_out, m_green_out, m_blue_out);
                    fail_count++;
                end else begin
                    want = pending_colors.pop_front();
                    check_field("red_out", want.red, m_red_out);
                    check_field("green_out", want.green, m_green_out);
                    check_field("blue_out", want.blue, m_blue_out);
                    check_field("frame_end_out", rys_pkg::PIX_W'(want.frame_end),
                                rys_pkg::PIX_W'(m_frame_end_out));
                end
                rcvd_count++;
            end
            // Queue the result for each input transfer; gains are stable here
            // because they only change with the pipeline empty.
            if (s_valid && s_ready) begin
                if (typed_tag)
                    pending_colors.push_back(want_tag);
                else
                    pending_colors.push_back(balance_pixel({s_red_in, s_green_in,
                                                            s_blue_in, s_frame_end}));
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sink pacing: random stall bursts, one long hold-off that backs the
    // pipeline up into s_ready, and a steady ready once the run goes calm.
    // ---------------------------------------------------------------------

    initial begin : sink_pacing
        bit held_once;
        held_once = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40))
                @(posedge aclk);
            if (!held_once && rcvd_count >= HOLD_AT) begin
                // Hold long enough for every stage to fill while pixels keep coming.
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge aclk);
            end else if (!calm) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19))
                    @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------------

    // Offer one pixel and hold it until the transfer. Valid is only lowered
    // for an idle burst, so a back-to-back pixel never toggles it in one step.
    task automatic push_pixel(input pixel_t stim, input logic typed, input pixel_t want);
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19))
                @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_red_in    <= stim.red;
        s_green_in  <= stim.green;
        s_blue_in   <= stim.blue;
        s_frame_end <= stim.frame_end;
        typed_tag   <= typed;
        want_tag    <= want;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_count++;
    endtask

    // Stop offering and wait until every queued result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (rcvd_count < sent_count)
            @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [rys_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rys_pkg::GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            rys_pkg::REG_LUMA_GAIN:        gain_luma = data;
            rys_pkg::REG_BLUE_CHROMA_GAIN: gain_blue = data;
            rys_pkg::REG_RED_CHROMA_GAIN:  gain_red  = data;
            default:                       ;
        endcase
    endtask

    // Drain the pipeline, then program all three gains (and optionally poke
    // the unused index with junk). Leave the config channel idle afterwards.
    task automatic set_gains(input logic [rys_pkg::GAIN_W-1:0] gy,
                             input logic [rys_pkg::GAIN_W-1:0] gu,
                             input logic [rys_pkg::GAIN_W-1:0] gv, input logic poke_spare);
        wait_drained();
        if (poke_spare)
            cfg_write(REG_SPARE, rys_pkg::GAIN_W'($urandom_range(0, 255)));
        cfg_write(rys_pkg::REG_LUMA_GAIN, gy);
        cfg_write(rys_pkg::REG_BLUE_CHROMA_GAIN, gu);
        cfg_write(rys_pkg::REG_RED_CHROMA_GAIN, gv);
        cfg_valid <= 1'b0;
    endtask

    // Favor the rails so the clamps and wraps get hit often.
    function automatic logic [rys_pkg::PIX_W-1:0] random_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return rys_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        px.red       = random_level();
        px.green     = random_level();
        px.blue      = random_level();
        px.frame_end = ($urandom_range(0, 7) == 0);
        return px;
    endfunction

    initial begin : stimulus
        logic [rys_pkg::GAIN_W-1:0] gy, gu, gv;
        // Hold reset low, then release it.
        repeat (2)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: reprogram whenever a row asks for other gains.
        for (int i = 0; i < N_PROBES; i++) begin
            if (probe_tbl[i].spare || probe_tbl[i].gy != gain_luma ||
                probe_tbl[i].gu != gain_blue || probe_tbl[i].gv != gain_red)
                set_gains(probe_tbl[i].gy, probe_tbl[i].gu, probe_tbl[i].gv,
                          probe_tbl[i].spare);
            push_pixel(probe_tbl[i].stim, probe_tbl[i].typed, probe_tbl[i].want);
        end

        // Random phases, each under its own gain setting; the pipeline is
        // drained between phases, which also covers the full source pause.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    gy = rys_pkg::GAIN_UNITY;
                    gu = rys_pkg::GAIN_UNITY;
                    gv = rys_pkg::GAIN_UNITY;
                end
                1: begin
                    gy = '1;
                    gu = '1;
                    gv = '1;
                end
                2: begin
                    gy = '0;
                    gu = '1;
                    gv = 8'd1;
                end
                default: begin
                    gy = rys_pkg::GAIN_W'($urandom_range(0, 255));
                    gu = rys_pkg::GAIN_W'($urandom_range(0, 255));
                    gv = rys_pkg::GAIN_W'($urandom_range(0, 255));
                end
            endcase
            if (ph == N_PHASES - 1)
                calm = 1'b1;
            set_gains(gy, gu, gv, ph == 3);
            repeat (PHASE_ITEMS)
                push_pixel(random_pixel(), 1'b0, '0);
        end

        // Let the last results drain, then watch a little longer for strays.
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge aclk);
        if (pending_colors.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_colors.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** rgb_yuv_scale_rgb_pixel_top: PASSED **");
        else
            $display("** rgb_yuv_scale_rgb_pixel_top: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("** rgb_yuv_scale_rgb_pixel_top: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rys_pkg.sv
hdl/rys_fwd.sv
hdl/rys_scale.sv
hdl/rys_inv.sv
hdl/rys_clamp.sv
hdl/rgb_yuv_scale_rgb_pixel_top.sv
hdl/rys_check.sv
verif/rgb_yuv_scale_rgb_pixel_top_tb.sv
